@@ rtl/pfba_pkg.sv @@
// Shared types and constants for the page frame bitmap allocator.
// Holds request field widths, command codes and the controller/datapath links.
// No dependencies.
package pfba_pkg;

	localparam int FRAME_W       = 20;
	localparam int CMD_W         = 2;
	localparam int S_DATA_W      = 24;
	localparam int M_DATA_W      = 24;
	localparam int MAP_WORDS_DEF = 32768;
	localparam int WORD_BITS_DEF = 32;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ALLOC = 2'd0;
	localparam cmd_t CMD_FREE  = 2'd1;
	localparam cmd_t CMD_MARK  = 2'd2;

	typedef struct packed {
		logic capture;
		logic rmw_rd;
		logic rmw_wr;
		logic scan_start;
		logic scan_rd;
		logic scan_take;
		logic scan_next;
		logic scan_empty;
		logic res_fail;
		logic clr_wr;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic in_range;
		logic has_free;
		logic word_nz;
		logic scan_last;
		logic clr_last;
	} dp_sts_t;

endpackage

@@ rtl/pfba_ctrl.sv @@
// Controller state machine of the page frame bitmap allocator.
// Sequences clearing, request decode, read-modify-write, scan and response.
// Depends on pfba_pkg.
module pfba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pfba_pkg::dp_sts_t sts,
	output pfba_pkg::dp_cmd_t ctl
);
	import pfba_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_RMW   = 3'd3;
	localparam logic [2:0] S_SRD   = 3'd4;
	localparam logic [2:0] S_SCHK  = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.cmd)
					CMD_ALLOC: begin
						if (sts.has_free) begin
							ctl.scan_start = 1'b1;
							state_d        = S_SRD;
						end else begin
							ctl.res_fail = 1'b1;
							state_d      = S_RESP;
						end
					end
					CMD_FREE, CMD_MARK: begin
						if (sts.in_range) begin
							ctl.rmw_rd = 1'b1;
							state_d    = S_RMW;
						end else begin
							ctl.res_fail = 1'b1;
							state_d      = S_RESP;
						end
					end
					default: begin
						ctl.res_fail = 1'b1;
						state_d      = S_RESP;
					end
				endcase
			end
			S_RMW: begin
				ctl.rmw_wr = 1'b1;
				state_d    = S_RESP;
			end
			S_SRD: begin
				ctl.scan_rd = 1'b1;
				state_d     = S_SCHK;
			end
			S_SCHK: begin
				if (sts.word_nz) begin
					ctl.scan_take = 1'b1;
					state_d       = S_RESP;
				end else if (sts.scan_last) begin
					ctl.scan_empty = 1'b1;
					state_d        = S_RESP;
				end else begin
					ctl.scan_next = 1'b1;
					state_d       = S_SRD;
				end
			end
			S_RESP: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/pfba_dp.sv @@
// Datapath of the page frame bitmap allocator: bitmap memory, frame split,
// scan pointer, free-range hints, lowest-bit search and result registers.
// Depends on pfba_pkg.
module pfba_dp #(
	parameter int MAP_WORDS = pfba_pkg::MAP_WORDS_DEF,
	parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfba_pkg::dp_cmd_t             ctl,
	output pfba_pkg::dp_sts_t             sts,
	input  logic [pfba_pkg::S_DATA_W-1:0] s_tdata,
	output logic [pfba_pkg::M_DATA_W-1:0] m_tdata
);
	import pfba_pkg::*;

	localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW  = $clog2(MAP_WORDS + 1);
	localparam int BW  = $clog2(WORD_BITS);
	localparam int K   = FRAME_W + BW;
	localparam int PW  = AW + BW + 1;
	localparam int FW2 = (PW > FRAME_W) ? PW : FRAME_W;
	localparam logic [K-1:0] RECIP =
		K'(((longint'(1) << K) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS));

	function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BW'(i);
			end
		end
		return r;
	endfunction

	cmd_t                 in_cmd;
	logic [FRAME_W-1:0]   in_frame;
	logic [FRAME_W+K-1:0] prod;
	cmd_t                 cmd_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [FRAME_W-1:0]   q_q;
	logic [FRAME_W-1:0]   qmul;
	logic [FRAME_W-1:0]   rem;
	logic [BW-1:0]        bit_q;
	logic [AW-1:0]        q_word;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        wa;
	logic [AW-1:0]        ra;
	logic [WORD_BITS-1:0] wd;
	logic [WORD_BITS-1:0] rmw_oh;
	logic [WORD_BITS-1:0] take_oh;
	logic [BW-1:0]        low_idx;
	logic [FW2-1:0]       take_frame;

	logic [AW-1:0]        addr_q;
	logic [HW-1:0]        lo_q;
	logic [HW-1:0]        hi_q;
	logic [HW-1:0]        q_word_h;
	logic [HW-1:0]        addr_h;

	logic                 res_granted_q;
	logic [FRAME_W-1:0]   res_frame_q;
	logic                 out_granted_q;
	logic [FRAME_W-1:0]   out_frame_q;

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_frame = s_tdata[CMD_W +: FRAME_W];
	assign prod     = {{K{1'b0}}, in_frame} * {{FRAME_W{1'b0}}, RECIP};

	assign qmul     = q_q * FRAME_W'(WORD_BITS);
	assign rem      = frame_q - qmul;
	assign q_word   = q_q[AW-1:0];
	assign q_word_h = HW'(q_word);
	assign addr_h   = HW'(addr_q);

	assign low_idx    = lowest_set(rd_q);
	assign rmw_oh     = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q;
	assign take_oh    = {{(WORD_BITS-1){1'b0}}, 1'b1} << low_idx;
	assign take_frame = FW2'(addr_q) * FW2'(WORD_BITS) + FW2'(low_idx);

	assign mem_we = ctl.clr_wr | ctl.rmw_wr | ctl.scan_take;
	assign mem_re = ctl.rmw_rd | ctl.scan_rd;
	assign wa     = ctl.rmw_wr ? q_word : addr_q;
	assign ra     = ctl.rmw_rd ? q_word : addr_q;

	always_comb begin
		wd = '0;
		if (ctl.rmw_wr) begin
			wd = (cmd_q == CMD_FREE) ? (rd_q | rmw_oh) : (rd_q & ~rmw_oh);
		end else if (ctl.scan_take) begin
			wd = rd_q & ~take_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		if (mem_re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= in_cmd;
			frame_q <= in_frame;
			q_q     <= prod[FRAME_W+K-1:K];
		end
		if (ctl.rmw_rd) begin
			bit_q <= rem[BW-1:0];
		end
		if (ctl.rmw_wr) begin
			res_granted_q <= 1'b1;
			res_frame_q   <= '0;
		end else if (ctl.scan_take) begin
			res_granted_q <= 1'b1;
			res_frame_q   <= take_frame[FRAME_W-1:0];
		end else if (ctl.scan_empty || ctl.res_fail) begin
			res_granted_q <= 1'b0;
			res_frame_q   <= '0;
		end
		if (ctl.load_out) begin
			out_granted_q <= res_granted_q;
			out_frame_q   <= res_frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else begin
			if (ctl.clr_wr || ctl.scan_next) begin
				addr_q <= addr_q + AW'(1);
			end else if (ctl.scan_start) begin
				addr_q <= lo_q[AW-1:0];
			end
			if (ctl.rmw_wr && cmd_q == CMD_FREE) begin
				if (q_word_h < lo_q) begin
					lo_q <= q_word_h;
				end
				if (q_word_h >= hi_q) begin
					hi_q <= q_word_h + HW'(1);
				end
			end else if (ctl.scan_take) begin
				lo_q <= addr_h;
			end else if (ctl.scan_empty) begin
				lo_q <= hi_q;
			end
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.in_range  = q_q < FRAME_W'(MAP_WORDS);
	assign sts.has_free  = lo_q < hi_q;
	assign sts.word_nz   = |rd_q;
	assign sts.scan_last = (addr_h + HW'(1)) >= hi_q;
	assign sts.clr_last  = addr_q == AW'(MAP_WORDS - 1);

	assign m_tdata = {{(M_DATA_W-FRAME_W-1){1'b0}}, out_frame_q, out_granted_q};

	a_hint_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("free-range low hint above high hint");

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hi_q <= HW'(MAP_WORDS))
		else $error("free-range high hint beyond the map");

	a_take_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_take |-> rd_q != '0)
		else $error("scan took a bit from an empty word");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_rd |-> addr_h < hi_q)
		else $error("scan read past the high hint");

	a_rmw_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rmw_wr |-> $past(ctl.rmw_rd) && q_q < FRAME_W'(MAP_WORDS))
		else $error("bitmap update without a prior in-range read");

endmodule

@@ rtl/page_frame_bitmap_allocator.sv @@
// Page frame bitmap allocator: one bit per 4 KiB frame, 1 = free, first fit.
//
// Requests enter on the s_ channel: command 0 allocates the lowest free frame,
// 1 frees page_frame, 2 marks page_frame used. Each request gives exactly one
// response on the m_ channel: granted and allocated_frame (zero unless an
// allocate succeeded). Free and mark-used of a frame past the map, an allocate
// with no free frame and command 3 answer granted 0 and change nothing.
// A free or mark-used reads its bitmap word and writes it back. An allocate
// scans bitmap words through the single read port, reading each word and then
// checking it, starting at the lowest word that can hold a free bit and stopping
// at the highest word ever freed; with no such word it answers without a scan.
// One request is in flight at a time; the next is accepted the cycle after its
// response is loaded. s_tready rises again once the response sits in the output
// register, even while the receiver stalls it. A second response waits in the
// controller until m_tready takes the first.
// After reset the bitmap is cleared to all used by a pass over all MAP_WORDS
// words (32768 by default) with s_tready low.
module page_frame_bitmap_allocator #(
	parameter int MAP_WORDS = pfba_pkg::MAP_WORDS_DEF,
	parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pfba_pkg::S_DATA_W-1:0] s_tdata, // command[1:0], page_frame[21:2]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pfba_pkg::M_DATA_W-1:0] m_tdata  // granted[0], allocated_frame[20:1]
);
	import pfba_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	pfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pfba_dp #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule
